// File: design/meter_frame_receiver_core_assert.svh
// Assertion macros shared by the meter frame receiver modules.
// Each macro assumes clk_i and rst_ni are in scope; bodies are empty for synthesis.
`ifndef METER_FRAME_RECEIVER_CORE_ASSERT_SVH
`define METER_FRAME_RECEIVER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define MFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define MFR_NEVER(lbl, cond, msg) \
  `MFR_ASSERT(lbl, !(cond), msg)
`else
`define MFR_ASSERT(lbl, prop, msg)
`define MFR_NEVER(lbl, cond, msg)
`endif
`endif

// File: design/mfr_pkg.sv
// Shared types and constants of the meter frame receiver.
// No dependencies; used by the front, queue, back and top level.
`default_nettype none

package mfr_pkg;

  // Command codes of an input transaction.
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Frame markers and framing overhead.
  localparam logic [7:0]  MARK_START     = 8'h68;
  localparam logic [7:0]  MARK_END       = 8'h16;
  localparam int unsigned FRAME_OVERHEAD = 11;
  localparam logic [15:0] GAP_RESET      = 16'd300;

  // Fixed header positions.
  localparam int unsigned POS_MARK0 = 0;
  localparam int unsigned POS_MARK1 = 7;
  localparam int unsigned POS_LEN   = 9;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_TAKEN    = 3'd0,
    ST_DONE     = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_BAD_END  = 3'd3,
    ST_TIMEOUT  = 3'd4,
    ST_QUIET    = 3'd5,
    ST_READ     = 3'd6
  } status_e;

  // Work that the back end carries out for one transaction.
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_NOTE
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    status_e    status;
    logic [8:0] frame_length;
    logic [7:0] data;
    logic       in_range;
  } op_t;

endpackage

`default_nettype wire

// File: design/mfr_if.sv
// Valid/ready channel interfaces for input items and result items.
// Standalone; field widths follow the receiver's item formats.
`default_nettype none

// Input channel: command with received byte or read address.
interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;
  logic [7:0] read_addr;

  modport source (output valid, output command, output rx_byte, output read_addr,
                  input ready);
  modport sink   (input valid, input command, input rx_byte, input read_addr,
                  output ready);
endinterface

// Result channel: status, completed frame length and read data.
interface mfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [8:0] frame_length;
  logic [7:0] read_data;

  modport source (output valid, output status, output frame_length, output read_data,
                  input ready);
  modport sink   (input valid, input status, input frame_length, input read_data,
                  output ready);
endinterface

`default_nettype wire

// File: design/mfr_front.sv
// Front end: accepts transactions, tracks frame position and gap timer, classifies.
// Depends on mfr_pkg and mfr_in_if; feeds mfr_queue.
`default_nettype none
`include "meter_frame_receiver_core_assert.svh"

module mfr_front #(
  parameter int unsigned STORE_DEPTH = 256,
  parameter int unsigned AW          = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  mfr_in_if.sink            item_i,
  input  wire logic         gap_limit_we_i,
  input  wire logic [15:0]  gap_limit_i,
  input  wire logic         q_ready_i,
  output logic              push_o,
  output mfr_pkg::op_t      op_o,
  output logic [AW-1:0]     addr_o
);

  localparam int unsigned PW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CW = (PW > 9) ? PW + 1 : 10;

  logic [PW-1:0] pos_q, pos_d, p;
  logic [15:0]   cnt_q, cnt_d, gap_next;
  logic          armed_q, armed_d;
  logic [7:0]    len_q, len_d;
  logic [15:0]   gap_limit_q;
  logic [CW-1:0] end_pos, len_one;
  logic [AW+7:0] ra_ext;

  assign item_i.ready = q_ready_i;

  // Position after the wrap at the store depth, and derived compares.
  assign p        = (pos_q == PW'(STORE_DEPTH)) ? '0 : pos_q;
  assign gap_next = cnt_q + 16'd1;
  assign end_pos  = CW'(len_q) + CW'(mfr_pkg::FRAME_OVERHEAD);
  assign len_one  = CW'(p) + CW'(1);
  assign ra_ext   = {{AW{1'b0}}, item_i.read_addr};

  // Classification of the accepted transaction and next state.
  always_comb begin
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    armed_d = armed_q;
    len_d   = len_q;
    push_o  = 1'b0;
    addr_o  = p[AW-1:0];
    op_o    = '{kind: mfr_pkg::OP_NOTE, status: mfr_pkg::ST_TAKEN,
                frame_length: '0, data: item_i.rx_byte, in_range: 1'b0};
    if (item_i.valid && q_ready_i) begin
      case (item_i.command)
        mfr_pkg::CMD_BYTE: begin
          push_o     = 1'b1;
          op_o.kind  = mfr_pkg::OP_WRITE;
          cnt_d      = '0;
          armed_d    = 1'b1;
          if (p == PW'(mfr_pkg::POS_MARK0) || p == PW'(mfr_pkg::POS_MARK1)) begin
            if (item_i.rx_byte != mfr_pkg::MARK_START) begin
              pos_d       = '0;
              op_o.status = mfr_pkg::ST_MISMATCH;
            end else begin
              pos_d = p + PW'(1);
            end
          end else if (p <= PW'(mfr_pkg::POS_LEN)) begin
            pos_d = p + PW'(1);
            if (p == PW'(mfr_pkg::POS_LEN)) begin
              len_d = item_i.rx_byte;
            end
          end else if (CW'(p) >= end_pos) begin
            pos_d = '0;
            if (item_i.rx_byte == mfr_pkg::MARK_END) begin
              op_o.status       = mfr_pkg::ST_DONE;
              op_o.frame_length = len_one[8:0];
              armed_d           = 1'b0;
            end else begin
              op_o.status = mfr_pkg::ST_BAD_END;
            end
          end else begin
            pos_d = p + PW'(1);
          end
        end
        mfr_pkg::CMD_TICK: begin
          push_o      = 1'b1;
          op_o.status = mfr_pkg::ST_QUIET;
          if (armed_q) begin
            cnt_d = gap_next;
            if (gap_next >= gap_limit_q) begin
              pos_d       = '0;
              armed_d     = 1'b0;
              op_o.status = mfr_pkg::ST_TIMEOUT;
            end
          end
        end
        mfr_pkg::CMD_READ: begin
          push_o        = 1'b1;
          op_o.kind     = mfr_pkg::OP_READ;
          op_o.status   = mfr_pkg::ST_READ;
          op_o.in_range = (32'(item_i.read_addr) < 32'(STORE_DEPTH));
          addr_o        = ra_ext[AW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Frame position, gap timer and configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      cnt_q       <= '0;
      armed_q     <= 1'b0;
      gap_limit_q <= mfr_pkg::GAP_RESET;
    end else begin
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      armed_q <= armed_d;
      if (gap_limit_we_i) begin
        gap_limit_q <= gap_limit_i;
      end
    end
  end

  // Length byte copy; meaningful once position nine has been written.
  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

  `MFR_ASSERT(a_pos_range, pos_q <= PW'(STORE_DEPTH), "frame position beyond store depth")
  `MFR_ASSERT(a_timeout_disarms, push_o && op_o.status == mfr_pkg::ST_TIMEOUT |=> !armed_q, "timeout left timer armed")
  `MFR_ASSERT(a_done_end_mark, push_o && op_o.status == mfr_pkg::ST_DONE |-> item_i.rx_byte == mfr_pkg::MARK_END, "frame done without end mark")

endmodule

`default_nettype wire

// File: design/mfr_queue.sv
// Short first-in first-out queue that decouples the front end from the back end.
// Depends on mfr_pkg for its depth.
`default_nettype none
`include "meter_frame_receiver_core_assert.svh"

module mfr_queue #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              ready_o,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic [W-1:0]      data_o
);

  localparam int unsigned D  = mfr_pkg::QUEUE_DEPTH;
  localparam int unsigned PTW = (D > 1) ? $clog2(D) : 1;
  localparam int unsigned CNW = $clog2(D + 1);

  logic [W-1:0]   slot_q [D];
  logic [PTW-1:0] wr_q, rd_q;
  logic [CNW-1:0] count_q;

  assign ready_o = (count_q != CNW'(D));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTW'(D - 1)) ? '0 : wr_q + PTW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTW'(D - 1)) ? '0 : rd_q + PTW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  `MFR_ASSERT(a_count_bound, count_q <= CNW'(D), "queue count beyond depth")
  `MFR_NEVER(a_no_overflow, push_i && !ready_o, "push into full queue")
  `MFR_NEVER(a_no_underflow, pop_i && !valid_o, "pop from empty queue")

endmodule

`default_nettype wire

// File: design/mfr_back.sv
// Back end: frame store memory and the result output register.
// Depends on mfr_pkg and mfr_out_if; drains mfr_queue.
`default_nettype none
`include "meter_frame_receiver_core_assert.svh"

module mfr_back #(
  parameter int unsigned STORE_DEPTH = 256,
  parameter int unsigned AW          = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire mfr_pkg::op_t  op_i,
  input  wire logic [AW-1:0] addr_i,
  output logic               pop_o,
  mfr_out_if.source          result_o
);

  logic [7:0]       store_q [STORE_DEPTH];
  logic             valid_q;
  mfr_pkg::status_e status_q;
  logic [8:0]       flen_q;
  logic [7:0]       rdata_q;

  // Take the next operation when the output register is free or drains.
  assign pop_o = q_valid_i && (!valid_q || result_o.ready);

  assign result_o.valid        = valid_q;
  assign result_o.status       = status_q;
  assign result_o.frame_length = flen_q;
  assign result_o.read_data    = rdata_q;

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (result_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Store write, registered store read and result payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= op_i.status;
      flen_q   <= op_i.frame_length;
      if (op_i.kind == mfr_pkg::OP_READ && op_i.in_range) begin
        rdata_q <= store_q[addr_i];
      end else begin
        rdata_q <= '0;
      end
      if (op_i.kind == mfr_pkg::OP_WRITE) begin
        store_q[addr_i] <= op_i.data;
      end
    end
  end

  `MFR_ASSERT(a_data_only_read, valid_q && status_q != mfr_pkg::ST_READ |-> rdata_q == 8'd0, "read data outside read result")
  `MFR_ASSERT(a_len_only_done, valid_q && status_q != mfr_pkg::ST_DONE |-> flen_q == 9'd0, "frame length outside frame done")
  `MFR_ASSERT(a_pop_loads, pop_o |=> valid_q, "popped operation not presented")

endmodule

`default_nettype wire

// File: design/meter_frame_receiver_core.sv
// Meter frame receiver: one input transaction per cycle while the queue has room,
// one result per command. A result passes through the queue entry and then the
// output register; throughput is set by the single store port in the back end,
// with the two-entry queue absorbing output stalls.
// Reset clears position, gap timer and queue and loads a gap limit of 300 ticks;
// store contents stay undefined until written, with no clearing pass.
`default_nettype none

module meter_frame_receiver_core #(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  mfr_in_if.sink           item_i,
  mfr_out_if.source        result_o,
  input  wire logic        gap_limit_we_i,
  input  wire logic [15:0] gap_limit_i
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned QW = AW + $bits(mfr_pkg::op_t);

  logic          push, q_ready, q_valid, pop;
  mfr_pkg::op_t  f_op, b_op;
  logic [AW-1:0] f_addr, b_addr;
  logic [QW-1:0] q_in, q_out;

  // Front end: position tracking and classification.
  mfr_front #(.STORE_DEPTH(STORE_DEPTH), .AW(AW)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .gap_limit_we_i (gap_limit_we_i),
    .gap_limit_i    (gap_limit_i),
    .q_ready_i      (q_ready),
    .push_o         (push),
    .op_o           (f_op),
    .addr_o         (f_addr)
  );

  assign q_in = {f_addr, f_op};

  // Decoupling queue.
  mfr_queue #(.W(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign b_addr = q_out[QW-1:QW-AW];
  assign b_op   = q_out[QW-AW-1:0];

  // Back end: store access and result register.
  mfr_back #(.STORE_DEPTH(STORE_DEPTH), .AW(AW)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .op_i      (b_op),
    .addr_i    (b_addr),
    .pop_o     (pop),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire
